@@ src/ufe_pkg.sv @@
// Shared types and constants for the UBX frame encoder.
package ufe_pkg;

  localparam logic CMD_START   = 1'b0;
  localparam logic CMD_PAYLOAD = 1'b1;

  localparam int  CFG_IDX_W      = 1;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_FIRST  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_SECOND = 1'd1;

  localparam logic [7:0] SYNC_FIRST_RST  = 8'hB5;
  localparam logic [7:0] SYNC_SECOND_RST = 8'h62;

  typedef struct packed {
    logic        command;
    logic [7:0]  msg_class;
    logic [7:0]  msg_id;
    logic [15:0] payload_length;
    logic [7:0]  data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_end;
    logic       run_last;
    logic       error;
  } out_item_t;

  typedef enum logic [1:0] {
    JOB_START = 2'd0,
    JOB_DATA  = 2'd1,
    JOB_ERR   = 2'd2
  } job_kind_t;

  typedef struct packed {
    job_kind_t   kind;
    logic [7:0]  byte0;
    logic [7:0]  byte1;
    logic [15:0] length;
    logic        last;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } job_push_t;

endpackage

@@ src/ufe_front.sv @@
// Front end: accepts input transfers, tracks frame state and classifies each item as a job.
module ufe_front import ufe_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  input  logic      push_ready,
  output job_push_t push
);

  logic        open_r;
  logic        open_nxt;
  logic [15:0] remaining_r;
  logic [15:0] remaining_nxt;
  logic        accept;

  assign in_ready = push_ready;
  assign accept   = in_valid & push_ready;

  always_comb begin
    push.valid      = accept;
    push.job.byte0  = in_data.msg_class;
    push.job.byte1  = in_data.msg_id;
    push.job.length = in_data.payload_length;
    push.job.last   = 1'b0;
    push.job.kind   = JOB_ERR;
    open_nxt        = open_r;
    remaining_nxt   = remaining_r;
    if (in_data.command == CMD_START) begin
      push.job.kind = JOB_START;
      open_nxt      = (in_data.payload_length != 16'd0);
      remaining_nxt = in_data.payload_length;
    end else if (open_r && (remaining_r != 16'd0)) begin
      push.job.kind  = JOB_DATA;
      push.job.byte0 = in_data.data_byte;
      push.job.last  = (remaining_r == 16'd1);
      remaining_nxt  = remaining_r - 16'd1;
      open_nxt       = (remaining_r != 16'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r      <= 1'b0;
      remaining_r <= 16'd0;
    end else if (accept) begin
      open_r      <= open_nxt;
      remaining_r <= remaining_nxt;
    end
  end

endmodule

@@ src/ufe_fifo.sv @@
// Short job queue between the front end and the byte sequencer.
module ufe_fifo import ufe_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  job_push_t push,
  output logic      push_ready,
  input  logic      pop,
  output logic      pop_valid,
  output job_t      pop_job
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
  localparam logic [PTR_W-1:0] LAST_C  = PTR_W'(DEPTH - 1);

  job_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count_r != DEPTH_C);
  assign pop_valid  = (count_r != '0);
  assign pop_job    = mem[rd_ptr_r];
  assign do_push    = push.valid & push_ready;
  assign do_pop     = pop & pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push.job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_C) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_C) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

@@ src/ufe_back.sv @@
// Back end: serializes jobs into frame bytes, keeps the Fletcher-8 sums and holds the output register.
module ufe_back import ufe_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] sync_first,
  input  logic [7:0] sync_second,
  input  logic       job_valid,
  input  job_t       job_in,
  output logic       job_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data
);

  job_t       cur_r;
  logic       cur_valid_r;
  logic [2:0] step_r;
  logic [7:0] sum_a_r;
  logic [7:0] sum_b_r;
  logic       out_valid_r;
  out_item_t  out_r;

  out_item_t  res;
  logic       acc;
  logic       clear;
  logic       done;
  logic       emit;
  logic [7:0] sum_a_nxt;
  logic [7:0] sum_b_nxt;

  always_comb begin
    res   = '0;
    acc   = 1'b0;
    clear = 1'b0;
    done  = 1'b0;
    unique case (cur_r.kind)
      JOB_START: begin
        unique case (step_r)
          3'd0: begin
            res.out_byte = sync_first;
            clear        = 1'b1;
          end
          3'd1: res.out_byte = sync_second;
          3'd2: begin
            res.out_byte = cur_r.byte0;
            acc          = 1'b1;
          end
          3'd3: begin
            res.out_byte = cur_r.byte1;
            acc          = 1'b1;
          end
          3'd4: begin
            res.out_byte = cur_r.length[7:0];
            acc          = 1'b1;
          end
          3'd5: begin
            res.out_byte = cur_r.length[15:8];
            acc          = 1'b1;
            res.run_last = (cur_r.length != 16'd0);
            done         = (cur_r.length != 16'd0);
          end
          3'd6: res.out_byte = sum_a_r;
          default: begin
            res.out_byte  = sum_b_r;
            res.frame_end = 1'b1;
            res.run_last  = 1'b1;
            done          = 1'b1;
          end
        endcase
      end
      JOB_DATA: begin
        priority if (step_r == 3'd0) begin
          res.out_byte = cur_r.byte0;
          acc          = 1'b1;
          res.run_last = !cur_r.last;
          done         = !cur_r.last;
        end else if (step_r == 3'd1) begin
          res.out_byte = sum_a_r;
        end else begin
          res.out_byte  = sum_b_r;
          res.frame_end = 1'b1;
          res.run_last  = 1'b1;
          done          = 1'b1;
        end
      end
      default: begin
        res.error    = 1'b1;
        res.run_last = 1'b1;
        done         = 1'b1;
      end
    endcase
  end

  assign emit      = cur_valid_r & (!out_valid_r | out_ready);
  assign job_pop   = !cur_valid_r | (emit & done);
  assign sum_a_nxt = sum_a_r + res.out_byte;
  assign sum_b_nxt = sum_b_r + sum_a_nxt;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      step_r      <= 3'd0;
      out_valid_r <= 1'b0;
      sum_a_r     <= 8'd0;
      sum_b_r     <= 8'd0;
    end else begin
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (emit && clear) begin
        sum_a_r <= 8'd0;
        sum_b_r <= 8'd0;
      end else if (emit && acc) begin
        sum_a_r <= sum_a_nxt;
        sum_b_r <= sum_b_nxt;
      end
      if (job_pop) begin
        cur_valid_r <= job_valid;
        step_r      <= 3'd0;
      end else if (emit) begin
        step_r <= step_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      cur_r <= job_in;
    end
    if (emit) begin
      out_r <= res;
    end
  end

endmodule

@@ src/ubx_frame_encoder_core.sv @@
// Top level of the UBX frame encoder: sync registers, front end, job queue and back end.
// Each input transfer passes the job queue, the back end's job register and the output register.
// The back end emits one output byte per cycle while the output side is ready; a payload item
// yields one byte (three on the last of a frame) and a start item six (eight at zero length).
// Inputs are accepted every cycle while the job queue has room, so header bursts are absorbed.
// Reset: synchronous active-low; clears frame state, sums and queue, sync bytes return to B5/62.
module ubx_frame_encoder_core import ufe_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  logic [7:0] sync_first_r;
  logic [7:0] sync_second_r;
  job_push_t  push;
  logic       push_ready;
  logic       pop;
  logic       pop_valid;
  job_t       pop_job;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_first_r  <= SYNC_FIRST_RST;
      sync_second_r <= SYNC_SECOND_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SYNC_FIRST:  sync_first_r  <= cfg_data;
        REG_SYNC_SECOND: sync_second_r <= cfg_data;
        default: ;
      endcase
    end
  end

  ufe_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_ready (push_ready),
    .push       (push)
  );

  ufe_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_valid  (pop_valid),
    .pop_job    (pop_job)
  );

  ufe_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .sync_first  (sync_first_r),
    .sync_second (sync_second_r),
    .job_valid   (pop_valid),
    .job_in      (pop_job),
    .job_pop     (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule
